[src/mpws_pkg.sv]
// ----------------------------------------------------------------------------
// Markov profile window scorer package
// Shared widths, register indexes and command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mpws_pkg;

   localparam int MAX_POSITIONS = 64;
   localparam int VALUE_BITS    = 16;
   localparam int INDEX_SLOTS   = 128;
   localparam int POS_BITS      = $clog2(MAX_POSITIONS);
   localparam int IDX_BITS      = $clog2(INDEX_SLOTS);
   localparam int TABLE_DEPTH   = MAX_POSITIONS * INDEX_SLOTS;
   localparam int TABLE_ABITS   = POS_BITS + IDX_BITS;

   localparam int RAW_BITS    = 22;
   localparam int ACC_BITS    = RAW_BITS + 1;
   localparam int COEF_BITS   = 16;
   localparam int PROD_BITS   = RAW_BITS + COEF_BITS;
   localparam int SCALED_BITS = 32;

   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 56;

   typedef enum logic [2:0] {
      CSR_MARKOV_ORDER  = 3'd0,
      CSR_WINDOW_LENGTH = 3'd1,
      CSR_TABLE_WIDTH   = 3'd2,
      CSR_SCALE_OFFSET  = 3'd3,
      CSR_SCALE_GAIN    = 3'd4
   } csr_index_type;

   typedef enum logic {
      CMD_TABLE_WRITE = 1'b0,
      CMD_BASE        = 1'b1
   } cmd_type;

   localparam logic [2:0] BASE_N    = 3'd4;
   localparam logic [1:0] ORDER_MAX = 2'd2;
   localparam logic [6:0] WIN_CAP   = 7'(MAX_POSITIONS);

   localparam logic signed [RAW_BITS-1:0]    RAW_MIN    = {1'b1, {(RAW_BITS-1){1'b0}}};
   localparam logic signed [RAW_BITS-1:0]    RAW_MAX    = {1'b0, {(RAW_BITS-1){1'b1}}};
   localparam logic signed [SCALED_BITS-1:0] SCALED_MIN = {1'b1, {(SCALED_BITS-1){1'b0}}};
   localparam logic signed [SCALED_BITS-1:0] SCALED_MAX = {1'b0, {(SCALED_BITS-1){1'b1}}};

   // control that rides along with the table read
   typedef struct packed {
      logic valid;
      logic last;
      logic do_add;
      logic hit_invalid;
   } lookup_ctrl_type;

endpackage

`default_nettype wire

[src/mpws_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module mpws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[src/markov_profile_window_scorer_core.sv]
// ----------------------------------------------------------------------------
// Markov profile window scorer core
// Sums position-specific log-odds values over a window of coded DNA bases
// and emits the raw and rescaled Q8.8 score on the last base.
// ----------------------------------------------------------------------------
// Pipeline: the result word for a last base is registered in turn after the
//   table read, the accumulate, the multiply and the round.
// Throughput: one word per cycle; the single table read port sets the rate.
//   Input stalls only when three results queue behind a blocked output.
// Reset: synchronous, active high; clears window state and pipeline valids;
//   presets config registers. The table is not cleared and holds garbage until written.
`default_nettype none

module markov_profile_window_scorer_core
   import mpws_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request stream
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // [2:0] base_code, [8:3] entry_position, [15:9] entry_index,
   // [31:16] entry_value
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic                     req_tlast,   // last_base
   input  wire logic                     req_tuser,   // cmd
   // response stream
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // [21:0] raw_score, [53:22] scaled_score, [55:54] zero
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                          rsp_tuser,   // invalid
   // configuration write channel
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [2:0]               csr_index,
   input  wire logic [15:0]              csr_data
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [1:0]                  order_ff;
   logic [6:0]                  wlen_ff;
   logic [6:0]                  twidth_ff;
   logic signed [COEF_BITS-1:0] offset_ff;
   logic signed [COEF_BITS-1:0] gain_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff  <= 2'd0;
         wlen_ff   <= 7'd1;
         twidth_ff <= 7'd125;
         offset_ff <= 16'sd0;
         gain_ff   <= 16'sd256;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_MARKOV_ORDER:  order_ff  <= csr_data[1:0];
            CSR_WINDOW_LENGTH: wlen_ff   <= csr_data[6:0];
            CSR_TABLE_WIDTH:   twidth_ff <= csr_data[6:0];
            CSR_SCALE_OFFSET:  offset_ff <= $signed(csr_data);
            CSR_SCALE_GAIN:    gain_ff   <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Request fields
   // ---------------------------------------------------------------------
   logic [2:0]            f_base;
   logic [5:0]            f_pos;
   logic [IDX_BITS-1:0]   f_idx;
   logic signed [15:0]    f_value;

   assign f_base  = req_tdata[2:0];
   assign f_pos   = req_tdata[8:3];
   assign f_idx   = req_tdata[15:9];
   assign f_value = $signed(req_tdata[31:16]);

   // ---------------------------------------------------------------------
   // Pipeline flow control
   //   stage 1: table read data + lookup control (accumulate)
   //   stage 2: final raw score, stage 3: product, stage 4: output word
   // Only last bases move past stage 1.
   // ---------------------------------------------------------------------
   lookup_ctrl_type s1_ff, s1_in;
   logic            s2_valid_ff, s3_valid_ff;
   logic            out_move, s3_free, s2_free, advance;
   logic            req_accept;

   assign out_move   = !rsp_tvalid || rsp_tready;
   assign s3_free    = !s3_valid_ff || out_move;
   assign s2_free    = !s2_valid_ff || s3_free;
   // hold stage 1 (and the input) only when a last base cannot move on
   assign advance    = !(s1_ff.valid && s1_ff.last) || s2_free;
   assign req_tready = advance;
   assign req_accept = req_tvalid && advance;

   // ---------------------------------------------------------------------
   // Stage 0: context, counter and table address
   // ---------------------------------------------------------------------
   logic [5:0]          ctx_ff, ctx_in;
   logic [6:0]          cnt_ff, cnt_in;
   logic [2:0]          base_c, p1, p2;
   logic [1:0]          ord;
   logic [6:0]          limit, pos, idx;
   logic                scored, in_window, hit_inv, is_base, tbl_we;
   logic [TABLE_ABITS-1:0] rd_addr, wr_addr;

   assign is_base = (cmd_type'(req_tuser) == CMD_BASE);
   assign base_c  = (f_base > BASE_N) ? BASE_N : f_base;
   assign ord     = (order_ff > ORDER_MAX) ? ORDER_MAX : order_ff;
   assign limit   = (wlen_ff < WIN_CAP) ? wlen_ff : WIN_CAP;
   assign p1      = ctx_ff[2:0];
   assign p2      = ctx_ff[5:3];

   always_comb begin
      case (ord)
         2'd0:    idx = 7'(base_c);
         2'd1:    idx = 7'(p1) * 7'd5 + 7'(base_c);
         default: idx = 7'(p2) * 7'd25 + 7'(p1) * 7'd5 + 7'(base_c);
      endcase
   end

   assign scored    = (cnt_ff >= 7'(ord));
   assign pos       = cnt_ff - 7'(ord);
   assign in_window = scored && (pos < limit);
   assign hit_inv   = in_window && (idx >= twidth_ff);
   assign rd_addr   = {POS_BITS'(pos), idx};

   // table writes: drop positions past the table
   assign tbl_we  = req_accept && !is_base &&
                    (32'(f_pos) < 32'(MAX_POSITIONS));
   assign wr_addr = {POS_BITS'(f_pos), f_idx};

   always_comb begin
      ctx_in = ctx_ff;
      cnt_in = cnt_ff;
      if (req_accept && is_base) begin
         if (req_tlast) begin
            ctx_in = 6'd0;
            cnt_in = 7'd0;
         end else begin
            ctx_in = {p1, base_c};
            cnt_in = (cnt_ff == 7'd127) ? cnt_ff : cnt_ff + 7'd1;
         end
      end
   end

   always_comb begin
      s1_in = s1_ff;
      if (advance) begin
         s1_in.valid       = req_tvalid && is_base;
         s1_in.last        = req_tlast;
         s1_in.do_add      = in_window && !hit_inv;
         s1_in.hit_invalid = hit_inv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff <= 6'd0;
         cnt_ff <= 7'd0;
         s1_ff  <= '0;
      end else begin
         ctx_ff <= ctx_in;
         cnt_ff <= cnt_in;
         s1_ff  <= s1_in;
      end
   end

   logic [VALUE_BITS-1:0] tbl_rd_data;

   mpws_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (wr_addr),
      .wr_data (VALUE_BITS'(f_value)),
      .rd_en   (advance),
      .rd_addr (rd_addr),
      .rd_data (tbl_rd_data)
   );

   // ---------------------------------------------------------------------
   // Stage 1: accumulate with saturation to the raw range
   // ---------------------------------------------------------------------
   logic signed [RAW_BITS-1:0] sum_ff, sum_in, sum_next;
   logic signed [ACC_BITS-1:0] acc_wide;
   logic                       inv_ff, inv_in, inv_next;
   logic signed [RAW_BITS-1:0] raw_ff, raw_in;
   logic                       raw_inv_ff, raw_inv_in, s2_valid_in;

   assign acc_wide = ACC_BITS'(sum_ff) + ACC_BITS'($signed(tbl_rd_data));

   always_comb begin
      sum_next = sum_ff;
      if (s1_ff.do_add) begin
         if (acc_wide > ACC_BITS'(RAW_MAX)) begin
            sum_next = RAW_MAX;
         end else if (acc_wide < ACC_BITS'(RAW_MIN)) begin
            sum_next = RAW_MIN;
         end else begin
            sum_next = acc_wide[RAW_BITS-1:0];
         end
      end
      inv_next = inv_ff || s1_ff.hit_invalid;
   end

   always_comb begin
      sum_in      = sum_ff;
      inv_in      = inv_ff;
      raw_in      = raw_ff;
      raw_inv_in  = raw_inv_ff;
      s2_valid_in = s2_valid_ff;
      if (s2_free) begin
         s2_valid_in = 1'b0;
      end
      if (advance && s1_ff.valid) begin
         if (s1_ff.last) begin
            // close the window: hand the score on and clear
            sum_in      = '0;
            inv_in      = 1'b0;
            raw_in      = inv_next ? RAW_MIN : sum_next;
            raw_inv_in  = inv_next;
            s2_valid_in = 1'b1;
         end else begin
            sum_in = sum_next;
            inv_in = inv_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         inv_ff      <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         sum_ff      <= sum_in;
         inv_ff      <= inv_in;
         s2_valid_ff <= s2_valid_in;
      end
      raw_ff     <= raw_in;
      raw_inv_ff <= raw_inv_in;
   end

   // ---------------------------------------------------------------------
   // Stage 2 -> 3: gain times raw score (Q16.16)
   // ---------------------------------------------------------------------
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [RAW_BITS-1:0]  raw3_ff;
   logic                        inv3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_free) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s3_free) begin
         prod_ff <= PROD_BITS'(gain_ff) * PROD_BITS'(raw_ff);
         raw3_ff <= raw_ff;
         inv3_ff <= raw_inv_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3 -> 4: round to Q8.8, add offset, saturate
   // ---------------------------------------------------------------------
   logic signed [PROD_BITS:0]          biased;
   logic signed [PROD_BITS-8:0]        rounded;
   logic signed [SCALED_BITS:0]        scaled_wide;
   logic signed [SCALED_BITS-1:0]      scaled;

   assign biased      = (PROD_BITS+1)'(prod_ff) + (PROD_BITS+1)'(128);
   assign rounded     = biased[PROD_BITS:8];   // floor of quotient by 256
   assign scaled_wide = (SCALED_BITS+1)'(rounded) + (SCALED_BITS+1)'(offset_ff);

   always_comb begin
      if (inv3_ff) begin
         scaled = SCALED_MIN;
      end else if (scaled_wide > (SCALED_BITS+1)'(SCALED_MAX)) begin
         scaled = SCALED_MAX;
      end else if (scaled_wide < (SCALED_BITS+1)'(SCALED_MIN)) begin
         scaled = SCALED_MIN;
      end else begin
         scaled = scaled_wide[SCALED_BITS-1:0];
      end
   end

   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_move) begin
         rsp_valid_ff <= s3_valid_ff;
      end
      if (out_move) begin
         rsp_tdata <= {2'b00, scaled, raw3_ff};
         rsp_tuser <= inv3_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

[src/mpws_checker.sv]
// ----------------------------------------------------------------------------
// Markov profile window scorer port checker
// Watches the top-level ports and flags behavior the core must never show.
// ----------------------------------------------------------------------------
`default_nettype none

module mpws_checker
   import mpws_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input wire logic                     rsp_tuser,
   input wire logic                     csr_valid,
   input wire logic                     csr_ready
);

   // a stalled output word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("output word changed while stalled");

   // minus infinity pins both scores to their minimum
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[RAW_BITS-1:0] == RAW_MIN &&
         rsp_tdata[RAW_BITS+SCALED_BITS-1:RAW_BITS] == SCALED_MIN)
      else $error("invalid result without minimum scores");

   // nothing comes out of reset as a pending word
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a result needs a base word accepted after reset to pass down the pipeline
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3))
      else $error("result appeared too soon after reset");

   // the configuration channel never backs up
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write refused");

endmodule

bind markov_profile_window_scorer_core mpws_checker u_mpws_checker (.*);

`default_nettype wire

[tb/markov_profile_window_scorer_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Markov profile window scorer testbench
// Loads profile entries, streams coded bases through windows of every Markov
// order and checks each score word against a cycle-free scoring model kept
// in this bench. A short table of hand-picked words comes first; random
// windows under changing register settings and back-pressure follow.
// ----------------------------------------------------------------------------

module markov_profile_window_scorer_core_tb;
   import mpws_pkg::*;

   localparam int TARGET_WORDS  = 1900;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 4000;  // cycles with no handshake at all
   localparam int HOLD_CYCLES   = 300;
   localparam int RADIX         = 5;     // base-5 context index
   localparam int CNT_CAP       = 127;

   typedef struct {
      cmd_type     cmd;
      logic [2:0]  code;
      logic        last;
      logic [5:0]  pos;
      logic [6:0]  idx;
      logic [15:0] val;
   } req_word_type;

   typedef struct {
      logic [21:0] raw;
      logic [31:0] scaled;
      logic        inv;
   } score_type;

   typedef enum {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      req_word_type  w;
      csr_index_type reg_sel;
      logic [15:0]   reg_val;
      bit            typed;
      score_type     known;
   } plan_row_type;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     req_tlast  = 1'b0;
   logic                     req_tuser  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [2:0]               csr_index  = '0;
   logic [15:0]              csr_data   = '0;

   markov_profile_window_scorer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // scoring model: register copies, window state and profile contents
   int                cfg_order  = 0;
   int                cfg_window = 1;
   int                cfg_width  = 125;
   longint            offset_q88 = 0;
   longint            gain_q88   = 256;
   logic [5:0]        ctx_hist   = '0;
   int                base_cnt   = 0;
   longint            run_sum    = 0;
   bit                inv_seen   = 1'b0;
   logic signed [15:0] prof_tbl     [MAX_POSITIONS][INDEX_SLOTS];
   bit                 prof_written [MAX_POSITIONS][INDEX_SLOTS];

   score_type score_q[$];    // scores owed by the block, oldest first
   score_type no_score      = '{default: '0};
   int        error_count   = 0;
   int        words_sent    = 0;
   int        req_gap_pct   = 0;
   int        rsp_stall_pct = 0;
   int        hold_asked    = 0;
   int        hold_served   = 0;
   int        hold_left     = 0;
   int        quiet_cycles  = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   // Lookup the next base would make: true when it lands inside the window.
   function automatic bit next_lookup(input logic [2:0] code, output int pos,
                                      output int idx);
      int ord;
      int lim;
      int c;
      int p1;
      int p2;
      ord = (cfg_order > ORDER_MAX) ? ORDER_MAX : cfg_order;
      lim = (cfg_window < MAX_POSITIONS) ? cfg_window : MAX_POSITIONS;
      c   = (code > BASE_N) ? BASE_N : code;
      p1  = ctx_hist[2:0];
      p2  = ctx_hist[5:3];
      pos = base_cnt - ord;
      case (ord)
         0: idx = c;
         1: idx = RADIX * p1 + c;
         default: idx = RADIX * RADIX * p2 + RADIX * p1 + c;
      endcase
      return (base_cnt >= ord) && (pos < lim);
   endfunction

   task automatic note_csr(input csr_index_type r, input logic [15:0] d);
      case (r)
         CSR_MARKOV_ORDER:  cfg_order  = d[1:0];
         CSR_WINDOW_LENGTH: cfg_window = d[6:0];
         CSR_TABLE_WIDTH:   cfg_width  = d[6:0];
         CSR_SCALE_OFFSET:  offset_q88 = longint'($signed(d));
         CSR_SCALE_GAIN:    gain_q88   = longint'($signed(d));
         default: ;
      endcase
   endtask

   // Advance the model by one accepted word; report the score it releases.
   task automatic advance_model(input req_word_type w, output bit scored,
                                output score_type s);
      int         pos;
      int         idx;
      logic [2:0] c;
      longint     scaled;
      scored   = 1'b0;
      s.raw    = '0;
      s.scaled = '0;
      s.inv    = 1'b0;
      if (w.cmd == CMD_TABLE_WRITE) begin
         prof_tbl[w.pos][w.idx]     = w.val;
         prof_written[w.pos][w.idx] = 1'b1;
         return;
      end
      if (next_lookup(w.code, pos, idx)) begin
         if (idx >= cfg_width) begin
            inv_seen = 1'b1;
         end else begin
            run_sum += prof_tbl[pos][idx];
            if (run_sum > longint'(RAW_MAX)) run_sum = RAW_MAX;
            if (run_sum < longint'(RAW_MIN)) run_sum = RAW_MIN;
         end
      end
      c        = (w.code > BASE_N) ? BASE_N : w.code;
      ctx_hist = {ctx_hist[2:0], c};
      if (base_cnt < CNT_CAP) base_cnt++;
      if (!w.last) return;
      scored = 1'b1;
      if (inv_seen) begin
         s.raw    = RAW_MIN;
         s.scaled = SCALED_MIN;
      end else begin
         // Q16.16 product back to Q8.8, rounding half up
         scaled = offset_q88 + ((gain_q88 * run_sum + 128) >>> 8);
         if (scaled > longint'(SCALED_MAX)) scaled = SCALED_MAX;
         if (scaled < longint'(SCALED_MIN)) scaled = SCALED_MIN;
         s.raw    = run_sum[21:0];
         s.scaled = scaled[31:0];
      end
      s.inv    = inv_seen;
      ctx_hist = '0;
      base_cnt = 0;
      run_sum  = 0;
      inv_seen = 1'b0;
   endtask

   function automatic req_word_type write_word(input int pos, input int idx,
                                               input logic [15:0] val, input logic last);
      req_word_type w;
      w.cmd  = CMD_TABLE_WRITE;
      w.code = 3'($urandom_range(7));   // don't care on writes
      w.last = last;
      w.pos  = 6'(pos);
      w.idx  = 7'(idx);
      w.val  = val;
      return w;
   endfunction

   function automatic req_word_type base_word(input logic [2:0] code, input logic last);
      req_word_type w;
      w.cmd  = CMD_BASE;
      w.code = code;
      w.last = last;
      w.pos  = 6'($urandom_range(63));
      w.idx  = 7'($urandom_range(124));
      w.val  = 16'($urandom);
      return w;
   endfunction

   function automatic plan_row_type word_row(input req_word_type w);
      plan_row_type r;
      r.kind  = ROW_WORD;
      r.w     = w;
      r.typed = 1'b0;
      return r;
   endfunction

   function automatic plan_row_type scored_row(input logic [2:0] code,
                                               input logic [21:0] raw,
                                               input logic [31:0] scaled, input logic inv);
      plan_row_type r;
      r.kind         = ROW_WORD;
      r.w            = base_word(code, 1'b1);
      r.typed        = 1'b1;
      r.known.raw    = raw;
      r.known.scaled = scaled;
      r.known.inv    = inv;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input csr_index_type sel, input logic [15:0] d);
      plan_row_type r;
      r.kind    = ROW_CSR;
      r.reg_sel = sel;
      r.reg_val = d;
      return r;
   endfunction

   function automatic logic [15:0] pick_value();
      case ($urandom_range(5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(1023)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic set_idle_mode();
      if (words_sent < TARGET_WORDS / 3) begin
         req_gap_pct   = 24;
         rsp_stall_pct = 47;
      end else if (words_sent < 2 * TARGET_WORDS / 3) begin
         req_gap_pct   = 47;
         rsp_stall_pct = 24;
      end else begin
         req_gap_pct   = 0;
         rsp_stall_pct = 0;
      end
   endtask

   // Offer one word, hold it until taken, then log what it should produce.
   task automatic send_word(input req_word_type w, input bit typed, input score_type known);
      bit        scored;
      score_type s;
      while ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.cmd;
      req_tlast  <= w.last;
      req_tdata  <= {w.val, w.idx, w.pos, w.code};
      do @(posedge clock); while (!req_tready);
      advance_model(w, scored, s);
      if (scored) score_q.push_back(typed ? known : s);
      words_sent++;
   endtask

   // Registers change only with the block drained and settled.
   task automatic write_register(input csr_index_type sel, input logic [15:0] d);
      req_tvalid <= 1'b0;
      while (score_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      note_csr(sel, d);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Send a base, first loading any profile entry it would read unwritten.
   task automatic send_base(input logic [2:0] code, input logic last);
      int pos;
      int idx;
      if (next_lookup(code, pos, idx) && idx < cfg_width && !prof_written[pos][idx])
         send_word(write_word(pos, idx, pick_value(), 1'($urandom_range(1))), 1'b0,
                   no_score);
      send_word(base_word(code, last), 1'b0, no_score);
   endtask

   // One window of len bases; a negative fixed_code means random bases
   // with stray profile writes mixed in.
   task automatic send_window(input int len, input int fixed_code);
      logic [2:0] code;
      for (int i = 0; i < len; i++) begin
         if (fixed_code < 0 && $urandom_range(11) == 0)
            send_word(write_word($urandom_range(63), $urandom_range(124), pick_value(),
                                 1'($urandom_range(1))), 1'b0, no_score);
         if (fixed_code >= 0)
            code = 3'(fixed_code);
         else if ($urandom_range(15) == 0)
            code = 3'($urandom_range(7, 5));
         else
            code = 3'($urandom_range(4));
         send_base(code, i == len - 1);
      end
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  = hold_left - 1;
      end else if (hold_served != hold_asked) begin
         hold_served = hold_served + 1;
         hold_left   = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Compare each accepted score word with the oldest one owed.
   always @(posedge clock) begin : score_check
      score_type want_s;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (score_q.size() == 0) begin
            flag_mismatch("score word with none pending", rsp_tdata[31:0], '0);
         end else begin
            want_s = score_q.pop_front();
            if (rsp_tdata[21:0] !== want_s.raw)
               flag_mismatch("raw_score", rsp_tdata[21:0], want_s.raw);
            if (rsp_tdata[53:22] !== want_s.scaled)
               flag_mismatch("scaled_score", rsp_tdata[53:22], want_s.scaled);
            if (rsp_tuser !== want_s.inv)
               flag_mismatch("invalid", rsp_tuser, want_s.inv);
         end
      end
   end

   // Watchdog: end the run if no handshake happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      plan_row_type plan[$];
      int           phase;
      int           eff_ord;
      int           span;
      int           len;
      int           shape;
      int           c;
      logic [15:0]  order_v;
      logic [15:0]  window_v;
      logic [15:0]  width_v;
      logic [15:0]  ext_val;

      // Directed words. Reset settings: order 0, window 1, full width,
      // unity gain, zero offset.
      plan.push_back(word_row(write_word(0, 2, 16'h7FFF, 1'b1)));   // tlast ignored
      plan.push_back(scored_row(3'd2, 22'h007FFF, 32'h0000_7FFF, 1'b0));
      plan.push_back(word_row(write_word(0, 4, 16'h8000, 1'b0)));
      // code above N scores as N
      plan.push_back(scored_row(3'd7, 22'h3F8000, 32'hFFFF_8000, 1'b0));
      // width of one leaves only index 0 valid: minus infinity
      plan.push_back(csr_row(CSR_TABLE_WIDTH, 16'd1));
      plan.push_back(scored_row(3'd1, RAW_MIN, SCALED_MIN, 1'b1));
      plan.push_back(csr_row(CSR_TABLE_WIDTH, 16'd125));
      // order 3 behaves as order 2
      plan.push_back(csr_row(CSR_MARKOV_ORDER, 16'd3));
      plan.push_back(csr_row(CSR_WINDOW_LENGTH, 16'd2));
      plan.push_back(word_row(write_word(0, 7, 16'h0100, 1'b0)));   // A C -> G
      plan.push_back(word_row(write_word(1, 38, 16'h0200, 1'b1)));  // C G -> T
      plan.push_back(word_row(base_word(3'd0, 1'b0)));
      plan.push_back(word_row(base_word(3'd1, 1'b0)));
      plan.push_back(word_row(base_word(3'd2, 1'b0)));
      plan.push_back(word_row(base_word(3'd3, 1'b1)));
      // last base while the context is still filling: nothing summed
      plan.push_back(csr_row(CSR_WINDOW_LENGTH, 16'd64));
      plan.push_back(word_row(base_word(3'd2, 1'b0)));
      plan.push_back(scored_row(3'd0, 22'h000000, 32'h0000_0000, 1'b0));
      plan.push_back(csr_row(CSR_SCALE_OFFSET, 16'h7FFF));
      plan.push_back(csr_row(CSR_SCALE_GAIN, 16'h8000));
      plan.push_back(csr_row(CSR_MARKOV_ORDER, 16'd0));
      plan.push_back(word_row(base_word(3'd2, 1'b1)));

      wait (!reset);
      @(posedge clock);
      set_idle_mode();

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR)
            write_register(plan[i].reg_sel, plan[i].reg_val);
         else
            send_word(plan[i].w, plan[i].typed, plan[i].known);
      end

      // Random phases; each reprograms every register once drained.
      phase = 0;
      while (words_sent < TARGET_WORDS) begin
         set_idle_mode();
         if (phase == 1 || phase == 2) begin
            order_v  = 16'd0;
            window_v = 16'd64;
            width_v  = 16'd125;
         end else if (phase == 3) begin
            order_v  = 16'd0;
            window_v = 16'd1;
            width_v  = 16'd125;
         end else begin
            order_v = ($urandom_range(9) == 0) ? 16'd3 : 16'($urandom_range(2));
            case ($urandom_range(3))
               0: window_v = 16'd1;
               1: window_v = 16'd64;
               default: window_v = 16'($urandom_range(12, 1));
            endcase
            case ($urandom_range(5))
               0: width_v = 16'd1;
               1: width_v = 16'($urandom_range(125, 1));
               default: width_v = 16'd125;
            endcase
         end
         write_register(CSR_MARKOV_ORDER, order_v);
         write_register(CSR_WINDOW_LENGTH, window_v);
         write_register(CSR_TABLE_WIDTH, width_v);
         write_register(CSR_SCALE_OFFSET, pick_value());
         write_register(CSR_SCALE_GAIN, ($urandom_range(3) == 0) ? 16'd256 : pick_value());

         eff_ord = (cfg_order > ORDER_MAX) ? ORDER_MAX : cfg_order;
         span    = eff_ord + cfg_window;

         if (phase == 1 || phase == 2) begin
            // full window at one extreme value: largest and smallest raw sums
            c       = $urandom_range(4);
            ext_val = (phase == 1) ? 16'h7FFF : 16'h8000;
            for (int p = 0; p < MAX_POSITIONS; p++)
               send_word(write_word(p, c, ext_val, 1'($urandom_range(1))), 1'b0, no_score);
            send_window(MAX_POSITIONS, c);
         end else if (phase == 3) begin
            // long receiver hold-off against one-base windows: block backs up
            hold_asked++;
            repeat (40) send_window(1, -1);
         end else begin
            repeat (5) begin
               shape = $urandom_range(49);
               if (shape == 0)
                  len = $urandom_range(160, 130);        // base counter saturates
               else if (shape <= 5)
                  len = $urandom_range(span, 1);         // early last base
               else if (shape <= 9)
                  len = span + $urandom_range(20, 1);    // runs past the window
               else
                  len = span;
               send_window(len, -1);
            end
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      while (score_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
